// ----- src/crh_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crh_pkg
// Shared types and constants for the clamped range histogram.
// ----------------------------------------------------------------------------
package crh_pkg;

  localparam int DEFAULT_MAX_BINS = 256;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 16;
  localparam int INDEX_W  = 8;
  localparam int NBINS_W  = 9;
  localparam int CFG_W    = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int MIN_BINS = 3;

  typedef enum logic [1:0] {
    REG_RANGE_LOW      = 2'd0,
    REG_RANGE_HIGH     = 2'd1,
    REG_BINS_IN_USE    = 2'd2,
    REG_CLEAR_ON_FIRST = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_COUNT = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

endpackage
`default_nettype wire

// ----- src/clamped_range_histogram_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clamped_range_histogram_top
// Histogram of signed samples with underflow and overflow bins, held in one
// synchronous memory, with a serial divider for the inner bin number.
//
//   channel  signals                                         dir
//   item     item_valid item_stall cmd sample first_of_set   in
//            read_bin
//   result   result_valid result_stall bin_index bin_count   out
//   config   cfg_we cfg_index cfg_data                       in
//
// A read transaction, or a sample in an edge bin, goes through S_READ and
// S_RESP; an inner sample goes first through S_MUL and the one-bit-per-cycle
// divider in S_DIV. A first sample with clear_on_first set adds a clearing
// pass over all MAX_BINS bins; reset starts one too, with item_stall high.
// A result held by result_stall keeps the next transaction in its final cycle.
// ----------------------------------------------------------------------------
module clamped_range_histogram_top #(
  parameter int MAX_BINS = crh_pkg::DEFAULT_MAX_BINS
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire  crh_pkg::cfg_reg_t               cfg_index,
  input  wire  [crh_pkg::CFG_W-1:0]             cfg_data,
  input  wire                                   item_valid,
  output logic                                  item_stall,
  input  wire                                   cmd,
  input  wire  signed [crh_pkg::SAMPLE_W-1:0]   sample,
  input  wire                                   first_of_set,
  input  wire  [crh_pkg::INDEX_W-1:0]           read_bin,
  output logic                                  result_valid,
  input  wire                                   result_stall,
  output logic [crh_pkg::INDEX_W-1:0]           bin_index,
  output logic [crh_pkg::COUNT_W-1:0]           bin_count
);
  import crh_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam int NW = $clog2(MAX_BINS + 1);
  localparam int CW = $clog2(AW);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MUL, S_DIV, S_READ, S_RESP
  } state_t;

  logic [COUNT_W-1:0] mem [MAX_BINS];
  logic [COUNT_W-1:0] mem_rdata;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;

  logic signed [SAMPLE_W-1:0] range_low;
  logic signed [SAMPLE_W-1:0] range_high;
  logic [NBINS_W-1:0]         bins_in_use;
  logic                       clear_on_first;

  state_t             state;
  logic [AW-1:0]      clr_addr;
  logic               resume;
  logic               is_rd;
  logic               rd_oob;
  logic               edge_bin;
  logic [INDEX_W-1:0] rd_idx;
  logic [AW-1:0]      bin;
  logic [AW-1:0]      nm2;
  logic [SAMPLE_W-1:0] off;
  logic [SAMPLE_W-1:0] span;
  logic [SAMPLE_W-1:0] rem;
  logic [AW-1:0]      plow;
  logic [AW-1:0]      quo;
  logic [CW-1:0]      div_cnt;

  logic [NW-1:0]        n_used;
  logic                 accept;
  logic                 is_lt;
  logic                 is_ge;
  logic signed [SAMPLE_W:0] off_diff;
  logic signed [SAMPLE_W:0] span_diff;
  logic [SAMPLE_W+AW-1:0]   prod;
  logic [SAMPLE_W:0]    trial;
  logic                 q_bit;
  logic [AW-1:0]        quo_next;
  logic                 out_free;
  logic [COUNT_W-1:0]   count_inc;

  always_comb begin
    if (bins_in_use < NBINS_W'(MIN_BINS)) begin
      n_used = NW'(MIN_BINS);
    end else if (32'(bins_in_use) > MAX_BINS) begin
      n_used = NW'(MAX_BINS);
    end else begin
      n_used = NW'(bins_in_use);
    end
  end

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign is_lt      = sample < range_low;
  assign is_ge      = sample >= range_high;
  assign off_diff   = 17'(sample) - 17'(range_low);
  assign span_diff  = 17'(range_high) - 17'(range_low);
  assign prod       = (SAMPLE_W+AW)'(nm2) * (SAMPLE_W+AW)'(off);
  assign trial      = {rem, plow[AW-1]};
  assign q_bit      = trial >= {1'b0, span};
  assign quo_next   = AW'({quo, q_bit});
  assign out_free   = !result_valid || !result_stall;
  assign count_inc  = (mem_rdata == COUNT_MAX) ? COUNT_MAX : mem_rdata + 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bin;
    mem_wdata = count_inc;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == S_RESP && out_free && !is_rd) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[bin];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low      <= '0;
      range_high     <= 16'sd32767;
      bins_in_use    <= NBINS_W'(256);
      clear_on_first <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANGE_LOW:      range_low      <= cfg_data;
        REG_RANGE_HIGH:     range_high     <= cfg_data;
        REG_BINS_IN_USE:    bins_in_use    <= cfg_data[NBINS_W-1:0];
        REG_CLEAR_ON_FIRST: clear_on_first <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      resume       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_RESP) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(MAX_BINS - 1)) begin
            clr_addr <= '0;
            resume   <= 1'b0;
            if (!resume) begin
              state <= S_IDLE;
            end else if (edge_bin) begin
              state <= S_READ;
            end else begin
              state <= S_MUL;
            end
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (cmd == CMD_READ) begin
              is_rd  <= 1'b1;
              rd_oob <= 32'(read_bin) >= MAX_BINS;
              rd_idx <= read_bin;
              bin    <= AW'(read_bin);
              state  <= S_READ;
            end else begin
              is_rd    <= 1'b0;
              edge_bin <= is_lt || is_ge;
              bin      <= is_lt ? '0 : AW'(n_used - 1'b1);
              nm2      <= AW'(n_used - NW'(2));
              off      <= off_diff[SAMPLE_W-1:0];
              span     <= span_diff[SAMPLE_W-1:0];
              if (first_of_set && clear_on_first) begin
                resume <= 1'b1;
                state  <= S_CLEAR;
              end else if (is_lt || is_ge) begin
                state <= S_READ;
              end else begin
                state <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          {rem, plow} <= prod;
          div_cnt     <= CW'(AW - 1);
          state       <= S_DIV;
        end
        S_DIV: begin
          rem     <= q_bit ? SAMPLE_W'(trial - {1'b0, span}) : trial[SAMPLE_W-1:0];
          plow    <= plow << 1;
          quo     <= quo_next;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            bin   <= quo_next + 1'b1;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            result_valid <= 1'b1;
            if (is_rd) begin
              bin_index <= rd_idx;
              bin_count <= rd_oob ? '0 : mem_rdata;
            end else begin
              bin_index <= INDEX_W'(bin);
              bin_count <= count_inc;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
